// ===== rtl/core/sld_pkg.sv =====
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the display register controller.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int ADDR_W      = 4;
  localparam int PATTERN_W   = 16;
  localparam int SEG_WIDTH   = 12;

  localparam logic [15:0] TIMEOUT_RESET  = 16'h0300;
  localparam logic [7:0]  BAD_ADDR_REPLY = 8'hff;
  localparam logic [7:0]  TRAILER_REPLY  = 8'ha4;

  typedef enum logic [1:0] {
    CMD_SPI  = 2'd0,
    CMD_WDOG = 2'd1,
    CMD_SCAN = 2'd2
  } cmd_t;

  // pattern store write request
  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [PATTERN_W-1:0] wdata;
  } sld_wr_t;

endpackage

// ===== rtl/core/sld_store.sv =====
// ----------------------------------------------------------------------------
// sld_store
// Sixteen-entry pattern memory: one write port, one registered read port,
// per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module sld_store
  import sld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sld_wr_t              wr,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [PATTERN_W-1:0] rd_data
);

  logic [PATTERN_W-1:0]   mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [PATTERN_W-1:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.waddr] <= 1'b1;
    end
  end

  // write in the same cycle wins over the array contents
  always_ff @(posedge clk) begin
    if (wr.we && (wr.waddr == raddr)) begin
      rd_data_r <= wr.wdata;
    end else if (valid_r[raddr]) begin
      rd_data_r <= mem[raddr];
    end else begin
      rd_data_r <= '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/sld_core.sv =====
// ----------------------------------------------------------------------------
// sld_core
// Protocol, watchdog and scan state with the result register.
// ----------------------------------------------------------------------------
module sld_core
  import sld_pkg::*;
#(
  parameter int NUM_DIGITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  logic [1:0]           s1_cmd,
  input  logic [7:0]           s1_byte,
  input  logic [15:0]          timeout_limit,
  input  logic [PATTERN_W-1:0] rd_data,
  output sld_wr_t              wr,
  output logic [ADDR_W-1:0]    scan_rd_addr,
  output logic                 out_valid,
  output logic                 out_reply_load,
  output logic [7:0]           out_reply_byte,
  output logic                 out_scan_valid,
  output logic [SEG_WIDTH-1:0] out_segment_bits,
  output logic [15:0]          out_digit_onehot,
  output logic [1:0]           out_bank_select
);

  typedef enum logic [1:0] {
    PH_DIR  = 2'd0,
    PH_ADDR = 2'd1,
    PH_HI   = 2'd2,
    PH_LO   = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic              is_write_r, is_write_nxt;
  logic [ADDR_W-1:0] target_r, target_nxt;
  logic [15:0]       idle_r, idle_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [16:0]       idle_inc;

  logic                 out_valid_r;
  logic                 reply_load_r, reply_load_nxt;
  logic [7:0]           reply_byte_r, reply_byte_nxt;
  logic                 scan_valid_r, scan_valid_nxt;
  logic [SEG_WIDTH-1:0] segment_r, segment_nxt;
  logic [15:0]          onehot_r, onehot_nxt;
  logic [1:0]           bank_r, bank_nxt;

  function automatic logic [ADDR_W-1:0] step_digit(input logic [ADDR_W-1:0] d);
    logic [ADDR_W-1:0] r;
    if (d == ADDR_W'(NUM_DIGITS - 1)) r = '0;
    else r = d + 1'b1;
    return r;
  endfunction

  assign idle_inc = {1'b0, idle_r} + 17'd1;

  always_comb begin
    phase_nxt      = phase_r;
    is_write_nxt   = is_write_r;
    target_nxt     = target_r;
    idle_nxt       = idle_r;
    scan_nxt       = scan_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    wr             = '0;
    wr.waddr       = target_r;
    reply_load_nxt = 1'b0;
    reply_byte_nxt = '0;
    scan_valid_nxt = 1'b0;
    segment_nxt    = '0;
    onehot_nxt     = '0;
    bank_nxt       = '0;
    if (s1_valid) begin
      case (cmd_t'(s1_cmd))
        CMD_SPI: begin
          idle_nxt = '0;
          case (phase_r)
            PH_DIR: begin
              is_write_nxt = (s1_byte != 8'd0);
              phase_nxt    = PH_ADDR;
            end
            PH_ADDR: begin
              if (s1_byte >= 8'(NUM_DIGITS)) begin
                reply_load_nxt = 1'b1;
                reply_byte_nxt = BAD_ADDR_REPLY;
                phase_nxt      = PH_DIR;
              end else begin
                target_nxt = s1_byte[ADDR_W-1:0];
                phase_nxt  = PH_HI;
                // whole word fetched now; low byte kept for the next phase
                lo_nxt     = rd_data[7:0];
                if (!is_write_r) begin
                  reply_load_nxt = 1'b1;
                  reply_byte_nxt = rd_data[15:8];
                end
              end
            end
            PH_HI: begin
              if (!is_write_r) begin
                reply_load_nxt = 1'b1;
                reply_byte_nxt = lo_r;
              end else begin
                wr.we    = 1'b1;
                wr.wdata = {s1_byte, 8'h00};
                hi_nxt   = s1_byte;
              end
              phase_nxt = PH_LO;
            end
            PH_LO: begin
              // low half was cleared by the previous phase; the saved high byte and this byte form the word
              if (!is_write_r) begin
                reply_load_nxt = 1'b1;
                reply_byte_nxt = TRAILER_REPLY;
              end else begin
                wr.we    = 1'b1;
                wr.wdata = {hi_r, s1_byte};
              end
              phase_nxt = PH_DIR;
            end
            default: phase_nxt = PH_DIR;
          endcase
        end
        CMD_WDOG: begin
          if (idle_inc >= {1'b0, timeout_limit}) begin
            phase_nxt = PH_DIR;
            idle_nxt  = '0;
          end else begin
            idle_nxt = idle_inc[15:0];
          end
        end
        CMD_SCAN: begin
          scan_nxt       = step_digit(scan_r);
          scan_valid_nxt = 1'b1;
          segment_nxt    = rd_data[PATTERN_W-1:PATTERN_W-SEG_WIDTH];
          onehot_nxt     = 16'd1 << scan_nxt;
          bank_nxt       = scan_nxt[ADDR_W-1] ? 2'd2 : 2'd1;
        end
        default: ;
      endcase
    end
  end

  // read address for a scan word accepted now, seen after the current word
  assign scan_rd_addr = step_digit(scan_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DIR;
      is_write_r   <= 1'b0;
      target_r     <= '0;
      idle_r       <= '0;
      scan_r       <= '0;
      hi_r         <= '0;
      lo_r         <= '0;
      out_valid_r  <= 1'b0;
      reply_load_r <= 1'b0;
      reply_byte_r <= '0;
      scan_valid_r <= 1'b0;
      segment_r    <= '0;
      onehot_r     <= '0;
      bank_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      is_write_r   <= is_write_nxt;
      target_r     <= target_nxt;
      idle_r       <= idle_nxt;
      scan_r       <= scan_nxt;
      hi_r         <= hi_nxt;
      lo_r         <= lo_nxt;
      out_valid_r  <= s1_valid;
      reply_load_r <= reply_load_nxt;
      reply_byte_r <= reply_byte_nxt;
      scan_valid_r <= scan_valid_nxt;
      segment_r    <= segment_nxt;
      onehot_r     <= onehot_nxt;
      bank_r       <= bank_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reply_load   = reply_load_r;
  assign out_reply_byte   = reply_byte_r;
  assign out_scan_valid   = scan_valid_r;
  assign out_segment_bits = segment_r;
  assign out_digit_onehot = onehot_r;
  assign out_bank_select  = bank_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid |=> out_valid_r)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |=> !out_valid_r)
    else $error("result without an accepted word");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(reply_load_r && scan_valid_r))
    else $error("reply and scan in one result");

  a_scan_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    scan_valid_r |-> ($onehot(onehot_r) && (bank_r == 2'd1 || bank_r == 2'd2)))
    else $error("bad digit select");

  a_bad_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s1_cmd == CMD_SPI && phase_r == PH_ADDR && s1_byte >= 8'(NUM_DIGITS))
    |=> (phase_r == PH_DIR && reply_byte_r == BAD_ADDR_REPLY))
    else $error("out-of-range address did not restart protocol");

endmodule

// ===== rtl/core/spi_led_display_register_controller_top.sv =====
// ----------------------------------------------------------------------------
// spi_led_display_register_controller_top
// SPI register front end over a sixteen-digit pattern store, with watchdog
// and multiplexed display scan.
// ----------------------------------------------------------------------------
// One word is taken every clock: busy is held low and cfg_ready high. Each
// accepted word yields exactly one result, strobed on out_valid once it has
// passed the input register and then the result register; the store read
// for that word is issued at acceptance on the memory's single registered
// read port, with same-cycle writes bypassed. Results cannot be held off.
// Write timeout_limit only while no words are in flight.
// ----------------------------------------------------------------------------
module spi_led_display_register_controller_top
  import sld_pkg::*;
#(
  parameter int NUM_DIGITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_spi_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  output logic                 out_reply_load,
  output logic [7:0]           out_reply_byte,
  output logic                 out_scan_valid,
  output logic [SEG_WIDTH-1:0] out_segment_bits,
  output logic [15:0]          out_digit_onehot,
  output logic [1:0]           out_bank_select
);

  logic                 s1_valid_r;
  logic [1:0]           s1_cmd_r;
  logic [7:0]           s1_byte_r;
  logic [15:0]          timeout_r;
  logic                 accept;
  sld_wr_t              wr;
  logic [ADDR_W-1:0]    scan_rd_addr;
  logic [ADDR_W-1:0]    raddr;
  logic [PATTERN_W-1:0] rd_data;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      timeout_r  <= TIMEOUT_RESET;
    end else begin
      s1_valid_r <= accept;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r  <= in_cmd;
    s1_byte_r <= in_spi_byte;
  end

  assign raddr = (in_cmd == CMD_SCAN) ? scan_rd_addr : in_spi_byte[ADDR_W-1:0];

  sld_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  sld_core #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid_r),
    .s1_cmd           (s1_cmd_r),
    .s1_byte          (s1_byte_r),
    .timeout_limit    (timeout_r),
    .rd_data          (rd_data),
    .wr               (wr),
    .scan_rd_addr     (scan_rd_addr),
    .out_valid        (out_valid),
    .out_reply_load   (out_reply_load),
    .out_reply_byte   (out_reply_byte),
    .out_scan_valid   (out_scan_valid),
    .out_segment_bits (out_segment_bits),
    .out_digit_onehot (out_digit_onehot),
    .out_bank_select  (out_bank_select)
  );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SPI display register controller. Words
// (SPI bytes, watchdog ticks, scan ticks) are driven with random gaps and
// mirrored into a scoreboard that tracks the protocol, pattern store,
// watchdog and scan state, and checks every strobed result field by field.
// ----------------------------------------------------------------------------
module tb;
  import sld_pkg::*;

  localparam int          DIGITS       = 16;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_SLACK  = 4;
  localparam int          RANDOM_WORDS = 1880;
  localparam int          MAX_PRINTED  = 30;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [1:0]  BANK_LOW     = 2'd1;
  localparam logic [1:0]  BANK_HIGH    = 2'd2;

  typedef enum logic [1:0] {
    PH_DIR  = 2'd0,
    PH_ADDR = 2'd1,
    PH_HI   = 2'd2,
    PH_LO   = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 reply_load;
    logic [7:0]           reply_byte;
    logic                 scan_valid;
    logic [SEG_WIDTH-1:0] segment_bits;
    logic [15:0]          digit_onehot;
    logic [1:0]           bank_select;
  } outcome_t;

  class display_scoreboard;
    logic [15:0] limit;
    phase_t      phase;
    bit          wr_mode;
    logic [3:0]  target;
    logic [15:0] patterns [16];
    logic [15:0] idle_ticks;
    logic [3:0]  scan_pos;
    outcome_t    due [$];
    int          words, checked, replies, scans, errors;

    function new();
      limit      = TIMEOUT_RESET;
      phase      = PH_DIR;
      wr_mode    = 1'b0;
      target     = '0;
      idle_ticks = '0;
      scan_pos   = '0;
      foreach (patterns[i]) patterns[i] = '0;
    endfunction

    function void set_limit(logic [15:0] v);
      limit = v;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // advances the mirrored state by one word and returns the result it yields
    function outcome_t apply_event(logic [1:0] cmd, logic [7:0] b);
      outcome_t o;
      int       nxt;
      o = '0;
      case (cmd)
        CMD_SPI: begin
          idle_ticks = '0;
          case (phase)
            PH_DIR: begin
              wr_mode = (b != 8'h00);
              phase   = PH_ADDR;
            end
            PH_ADDR: begin
              if (int'(b) >= DIGITS) begin
                o.reply_load = 1'b1;
                o.reply_byte = BAD_ADDR_REPLY;
                phase        = PH_DIR;
              end else begin
                target = b[3:0];
                phase  = PH_HI;
                if (!wr_mode) begin
                  o.reply_load = 1'b1;
                  o.reply_byte = patterns[b[3:0]][15:8];
                end
              end
            end
            PH_HI: begin
              if (!wr_mode) begin
                o.reply_load = 1'b1;
                o.reply_byte = patterns[target][7:0];
              end else begin
                patterns[target] = {b, 8'h00};
              end
              phase = PH_LO;
            end
            default: begin
              if (!wr_mode) begin
                o.reply_load = 1'b1;
                o.reply_byte = TRAILER_REPLY;
              end else begin
                patterns[target] = patterns[target] | {8'h00, b};
              end
              phase = PH_DIR;
            end
          endcase
        end
        CMD_WDOG: begin
          nxt = int'(idle_ticks) + 1;
          if (nxt >= int'(limit)) begin
            phase      = PH_DIR;
            idle_ticks = '0;
          end else begin
            idle_ticks = nxt[15:0];
          end
        end
        CMD_SCAN: begin
          scan_pos       = 4'((int'(scan_pos) + 1) % DIGITS);
          o.scan_valid   = 1'b1;
          o.segment_bits = patterns[scan_pos][15:4];
          o.digit_onehot = 16'd1 << scan_pos;
          o.bank_select  = (scan_pos < 4'd8) ? BANK_LOW : BANK_HIGH;
        end
        default: ;
      endcase
      if (o.reply_load) replies++;
      if (o.scan_valid) scans++;
      return o;
    endfunction

    function void note_word(logic [1:0] cmd, logic [7:0] b);
      due.push_back(apply_event(cmd, b));
      words++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR: result %0d: %0s", checked, msg);
    endtask

    task compare_field(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%0s got %0h expected %0h", field, got, want));
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (due.size() == 0) begin
        report("result strobed with no word outstanding");
      end else begin
        want = due.pop_front();
        compare_field("reply_load", 16'(got.reply_load), 16'(want.reply_load));
        compare_field("reply_byte", 16'(got.reply_byte), 16'(want.reply_byte));
        compare_field("scan_valid", 16'(got.scan_valid), 16'(want.scan_valid));
        compare_field("segment_bits", 16'(got.segment_bits), 16'(want.segment_bits));
        compare_field("digit_onehot", got.digit_onehot, want.digit_onehot);
        compare_field("bank_select", 16'(got.bank_select), 16'(want.bank_select));
      end
      checked++;
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_cmd;
  logic [7:0]           in_spi_byte;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [15:0]          cfg_data;
  logic                 out_valid;
  logic                 out_reply_load;
  logic [7:0]           out_reply_byte;
  logic                 out_scan_valid;
  logic [SEG_WIDTH-1:0] out_segment_bits;
  logic [15:0]          out_digit_onehot;
  logic [1:0]           out_bank_select;

  outcome_t          seen;
  display_scoreboard sb;
  bit                steady;
  int                cycle_cnt = 0;
  int                settings  = 0;

  spi_led_display_register_controller_top #(
    .NUM_DIGITS(DIGITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_spi_byte     (in_spi_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_reply_load  (out_reply_load),
    .out_reply_byte  (out_reply_byte),
    .out_scan_valid  (out_scan_valid),
    .out_segment_bits(out_segment_bits),
    .out_digit_onehot(out_digit_onehot),
    .out_bank_select (out_bank_select)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign seen = {out_reply_load, out_reply_byte, out_scan_valid, out_segment_bits,
                 out_digit_onehot, out_bank_select};

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(seen);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // start stays high across back-to-back words; it is only lowered for a gap
  task automatic push_word(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_cmd      <= cmd;
    in_spi_byte <= b;
    do @(posedge clk); while (busy);
    sb.note_word(cmd, b);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
    settings++;
  endtask

  // direction, address, high, low; sometimes cut short, with ticks mixed in
  task automatic transaction();
    logic [7:0] frame [4];
    int         len;
    frame[0] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    frame[1] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                           : 8'($urandom_range(0, 15));
    frame[2] = 8'($urandom);
    frame[3] = 8'($urandom);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 4;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 6) == 0)
        push_word(($urandom_range(0, 1) == 0) ? CMD_WDOG : CMD_SCAN, 8'($urandom));
      push_word(CMD_SPI, frame[i]);
    end
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int pick;
    stop_at = sb.words + count;
    while (sb.words < stop_at) begin
      steady = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 9);
      if (pick < 6) begin
        transaction();
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 10)) push_word(CMD_WDOG, 8'($urandom));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 18)) push_word(CMD_SCAN, 8'($urandom));
      end else begin
        push_word(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [15:0] limits [6];
    sb          = new();
    steady      = 1'b0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_cmd      <= CMD_SPI;
    in_spi_byte <= 8'h00;
    cfg_valid   <= 1'b0;
    cfg_data    <= 16'h0000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full writes at both ends of the store, read back, bad addresses
    push_word(CMD_SPI, 8'h01); push_word(CMD_SPI, 8'h00);
    push_word(CMD_SPI, 8'hff); push_word(CMD_SPI, 8'hff);
    push_word(CMD_SPI, 8'h80); push_word(CMD_SPI, 8'h0f);
    push_word(CMD_SPI, 8'h12); push_word(CMD_SPI, 8'h34);
    push_word(CMD_SPI, 8'h00); push_word(CMD_SPI, 8'h0f);
    push_word(CMD_SPI, 8'h00); push_word(CMD_SPI, 8'h00);
    push_word(CMD_SPI, 8'h00); push_word(CMD_SPI, 8'h10);
    push_word(CMD_SPI, 8'h01); push_word(CMD_SPI, 8'hff);
    push_word(CMD_SCAN, 8'h00); push_word(CMD_SCAN, 8'hff);
    push_word(CMD_UNUSED, 8'haa);
    // a tick mid-frame must not restart the protocol at the default limit
    push_word(CMD_SPI, 8'h00); push_word(CMD_WDOG, 8'h00); push_word(CMD_SPI, 8'h00);

    // zero limit: every tick restarts the protocol
    write_timeout(16'h0000);
    push_word(CMD_SPI, 8'h00); push_word(CMD_WDOG, 8'h55);
    push_word(CMD_SPI, 8'h00); push_word(CMD_SPI, 8'h00);

    limits[0] = 16'd1;
    limits[1] = 16'd4;
    limits[2] = 16'($urandom_range(2, 12));
    limits[3] = 16'hffff;
    limits[4] = TIMEOUT_RESET;
    limits[5] = 16'($urandom);
    foreach (limits[i]) begin
      write_timeout(limits[i]);
      random_traffic(RANDOM_WORDS / 6);
    end

    drain();
    $display("Summary: %0d words, %0d results checked (%0d replies, %0d scan updates)",
             sb.words, sb.checked, sb.replies, sb.scans);
    $display("Summary: %0d timeout settings, %0d mismatching fields", settings, sb.errors);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
